// File: design/mcl_pkg.sv
package mcl_pkg;

    // result kinds, also used to tag jobs in the queue
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_TIMEOUT = 2'd2
    } t_kind;

    // input item modes
    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [7:0]  FRAME_LEAD  = 8'hFF;
    localparam logic [7:0]  FRAME_START = 8'h41;
    localparam logic [2:0]  FRAME_LAST  = 3'd6;
    localparam logic [2:0]  REPLY_BYTES = 3'd4;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;
    localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;

    localparam int QUEUE_DEPTH_DEF = 4;

    // one unit of work handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  dev;
        logic [7:0]  cmd;
        logic [15:0] data;   // frame argument, or reply value
        logic [7:0]  chk;
    } t_job;

endpackage

// File: design/mcl_front.sv
module mcl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_device_id,
    input  logic [7:0]          i_command,
    input  logic signed [15:0]  i_argument,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_write,
    input  logic [15:0]         i_cfg_data,
    output logic                o_push,
    output mcl_pkg::t_job       o_job
);

    logic        r_awaiting, n_awaiting;
    logic        r_start, n_start;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_reply [4];
    logic [7:0]  n_reply [4];
    logic [16:0] r_elapsed, n_elapsed;
    logic [15:0] r_timeout;
    logic [16:0] tick_elapsed;
    logic [7:0]  reply_sum;
    logic [15:0] arg_bits;

    assign arg_bits     = i_argument;
    assign reply_sum    = r_reply[0] + r_reply[1] + r_reply[2] + r_reply[3];
    assign tick_elapsed = (r_elapsed < mcl_pkg::ELAPSED_MAX) ? r_elapsed + 17'd1 : r_elapsed;

    always_comb begin
        n_awaiting = r_awaiting;
        n_start    = r_start;
        n_idx      = r_idx;
        n_reply    = r_reply;
        n_elapsed  = r_elapsed;
        o_push     = 1'b0;
        o_job.kind = mcl_pkg::KIND_TX;
        o_job.dev  = i_device_id;
        o_job.cmd  = i_command;
        o_job.data = arg_bits;
        o_job.chk  = i_device_id + i_command + arg_bits[7:0] + arg_bits[15:8];
        if (i_accept) begin
            case (i_mode)
                mcl_pkg::MODE_SEND: begin
                    o_push     = 1'b1;
                    n_reply    = '{default: 8'd0};
                    n_start    = 1'b0;
                    n_idx      = 3'd0;
                    n_elapsed  = 17'd0;
                    n_awaiting = 1'b1;
                end
                mcl_pkg::MODE_RX: begin
                    if (r_awaiting) begin
                        if (!r_start) begin
                            if (i_rx_byte == mcl_pkg::FRAME_START) begin
                                n_start = 1'b1;
                                n_idx   = 3'd0;
                            end
                        end else if (r_idx < mcl_pkg::REPLY_BYTES) begin
                            n_reply[r_idx[1:0]] = i_rx_byte;
                            n_idx = r_idx + 3'd1;
                        end else begin
                            // checksum byte: a mismatch restarts the hunt
                            n_start = 1'b0;
                            n_idx   = 3'd0;
                            if (reply_sum == i_rx_byte) begin
                                n_awaiting = 1'b0;
                                o_push     = 1'b1;
                                o_job.kind = mcl_pkg::KIND_REPLY;
                                o_job.data = {r_reply[3], r_reply[2]};
                            end
                        end
                    end
                end
                mcl_pkg::MODE_TICK: begin
                    if (r_awaiting) begin
                        n_elapsed = tick_elapsed;
                        if (tick_elapsed > {1'b0, r_timeout}) begin
                            n_awaiting = 1'b0;
                            n_start    = 1'b0;
                            n_idx      = 3'd0;
                            o_push     = 1'b1;
                            o_job.kind = mcl_pkg::KIND_TIMEOUT;
                            o_job.data = {r_reply[3], r_reply[2]};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_start    <= 1'b0;
            r_idx      <= 3'd0;
            r_reply    <= '{default: 8'd0};
            r_elapsed  <= 17'd0;
            r_timeout  <= mcl_pkg::TIMEOUT_RESET;
        end else begin
            r_awaiting <= n_awaiting;
            r_start    <= n_start;
            r_idx      <= n_idx;
            r_reply    <= n_reply;
            r_elapsed  <= n_elapsed;
            if (i_cfg_write) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

endmodule

// File: design/mcl_queue.sv
module mcl_queue #(
    parameter int DEPTH = mcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcl_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output mcl_pkg::t_job  o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    mcl_pkg::t_job   r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: design/mcl_back.sv
module mcl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  mcl_pkg::t_job       i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_tx_byte,
    output logic                o_frame_end,
    output logic signed [15:0]  o_reply_value
);

    logic               r_valid;
    logic [2:0]         r_pos;
    mcl_pkg::t_kind     r_kind;
    logic [7:0]         r_tx;
    logic               r_end;
    logic [15:0]        r_value;
    logic               advance, load, is_frame, last_byte;
    logic [7:0]         frame_byte;

    assign advance   = !r_valid || !i_stall;
    assign load      = advance && !i_empty;
    assign is_frame  = (i_head.kind == mcl_pkg::KIND_TX);
    assign last_byte = (r_pos == mcl_pkg::FRAME_LAST);
    assign o_pop     = load && (!is_frame || last_byte);

    always_comb begin
        case (r_pos)
            3'd0:    frame_byte = mcl_pkg::FRAME_LEAD;
            3'd1:    frame_byte = mcl_pkg::FRAME_START;
            3'd2:    frame_byte = i_head.dev;
            3'd3:    frame_byte = i_head.cmd;
            3'd4:    frame_byte = i_head.data[7:0];
            3'd5:    frame_byte = i_head.data[15:8];
            3'd6:    frame_byte = i_head.chk;
            default: frame_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else if (advance) begin
            r_valid <= !i_empty;
            if (load && is_frame) begin
                r_pos <= last_byte ? 3'd0 : r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_head.kind;
            if (is_frame) begin
                r_tx    <= frame_byte;
                r_end   <= last_byte;
                r_value <= 16'd0;
            end else begin
                r_tx    <= 8'd0;
                r_end   <= 1'b0;
                r_value <= i_head.data;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx;
    assign o_frame_end   = r_end;
    assign o_reply_value = r_value;

endmodule

// File: design/motor_command_link.sv
// motor_command_link: master side of a half-duplex motor-driver link
// input channel (i_in_valid / o_in_stall): one transfer per item; mode selects
//   send command (emits a 7-byte frame and opens a reply wait), received
//   serial byte, or one millisecond tick
// output channel (o_out_valid / i_out_stall): one transfer per result, either
//   a frame byte to transmit (o_frame_end on the checksum byte), a valid reply
//   or a reply timeout, both carrying bytes 2 and 3 of the reply buffer
// config channel (i_cfg_valid / o_cfg_ready): writes timeout_ms; ready is
//   always high, write only while the link is idle
// a result reaches the output through the queue write, then the output
//   register; frame bytes follow one per cycle unless the output is stalled
// throughput: one input item per cycle unless the queue is full; the front
//   updates link state in the cycle an item arrives, queues jobs, and the
//   back drains one result per cycle unless stalled; a send gives 7 bytes
// o_in_stall rises only when the job queue is full
// a stalled output holds its result; the front keeps taking items until
//   the queue fills
// reset (synchronous, active low) clears the queue, the output valid flag and
//   frame position, the reply state and buffer, and sets timeout_ms to 10
module motor_command_link #(
    parameter int QUEUE_DEPTH = mcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command / event input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_device_id,
    input  logic [7:0]          i_command,
    input  logic signed [15:0]  i_argument,
    input  logic [7:0]          i_rx_byte,
    // result output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_tx_byte,
    output logic                o_frame_end,
    output logic signed [15:0]  o_reply_value,
    // timeout register write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    logic           in_accept;
    logic           q_push, q_pop, q_full, q_empty;
    mcl_pkg::t_job  push_job, head_job;

    // stall only on a full queue, so every accepted item has room for its job
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    // front: classify items, track the reply wait, build jobs
    mcl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_mode      (i_mode),
        .i_device_id (i_device_id),
        .i_command   (i_command),
        .i_argument  (i_argument),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    // job queue between front and back
    mcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // back: serialize frames and deliver results through the output register
    mcl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_job),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_frame_end   (o_frame_end),
        .o_reply_value (o_reply_value)
    );

endmodule
